// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file ibvd_check.sv.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IBVD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibvd assertion failed");

// Next-cycle implication.
`define IBVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ibvd assertion failed");

`endif

// ===== hw/rtl/ibvd_pkg.sv =====
// ----------------------------------------------------------------------------
// ibvd_pkg
// Types, codes and code tables of the intra block VLC decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ibvd_pkg;

  localparam int COEFS_PER_BLOCK = 16;
  localparam int CODE_W          = 28;

  typedef enum logic [2:0] {
    KIND_DC  = 3'd0,
    KIND_AC  = 3'd1,
    KIND_BLK = 3'd2,
    KIND_ERR = 3'd3,
    KIND_END = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CFG_QSCALE = 3'd0,
    CFG_QLOW   = 3'd1,
    CFG_QHIGH  = 3'd2,
    CFG_BLIMIT = 3'd3,
    CFG_DCSTRT = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FAIL,
    ACT_DC,
    ACT_EOB,
    ACT_COEF
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EVAL,
    ST_MUL1,
    ST_MUL2,
    ST_BEND,
    ST_BLIM,
    ST_FINAL,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic [2:0] bit_idx;
    logic       fail;
    logic       dc;
    logic       eob;
    logic       coef;
    logic       mul;
    logic       ac_done;
    logic       bend;
    logic       halt;
    logic       push;
    kind_t      kind;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic k_over;
    logic k_last;
    logic lim_hit;
    logic halted;
    logic final_flag;
    logic push_ok;
    logic flush_ok;
    logic pend_v;
  } sts_t;

  function automatic logic [3:0] zz_pos(input logic [3:0] k);
    case (k)
      4'd0:    zz_pos = 4'd0;
      4'd1:    zz_pos = 4'd1;
      4'd2:    zz_pos = 4'd4;
      4'd3:    zz_pos = 4'd8;
      4'd4:    zz_pos = 4'd5;
      4'd5:    zz_pos = 4'd2;
      4'd6:    zz_pos = 4'd3;
      4'd7:    zz_pos = 4'd6;
      4'd8:    zz_pos = 4'd9;
      4'd9:    zz_pos = 4'd12;
      4'd10:   zz_pos = 4'd13;
      4'd11:   zz_pos = 4'd10;
      4'd12:   zz_pos = 4'd7;
      4'd13:   zz_pos = 4'd11;
      4'd14:   zz_pos = 4'd14;
      default: zz_pos = 4'd15;
    endcase
  endfunction

  // Rows are the leading zero count (2,3,4,6,7), columns the two code bits.
  function automatic logic [5:0] ac_run(input logic [2:0] z, input logic [1:0] sel);
    case ({z, sel})
      5'b010_00: ac_run = 6'd4;
      5'b010_01: ac_run = 6'd1;
      5'b010_11: ac_run = 6'd3;
      5'b011_00: ac_run = 6'd6;
      5'b011_01: ac_run = 6'd7;
      5'b011_10: ac_run = 6'd5;
      5'b100_00: ac_run = 6'd8;
      5'b100_01: ac_run = 6'd9;
      5'b100_11: ac_run = 6'd2;
      5'b110_00: ac_run = 6'd10;
      5'b110_01: ac_run = 6'd11;
      5'b110_11: ac_run = 6'd1;
      5'b111_00: ac_run = 6'd12;
      5'b111_01: ac_run = 6'd13;
      5'b111_11: ac_run = 6'd3;
      default:   ac_run = 6'd0;
    endcase
  endfunction

  function automatic logic [2:0] ac_mag(input logic [2:0] z, input logic [1:0] sel);
    case ({z, sel})
      5'b010_00: ac_mag = 3'd1;
      5'b010_01: ac_mag = 3'd2;
      5'b010_10: ac_mag = 3'd3;
      5'b010_11: ac_mag = 3'd1;
      5'b011_11: ac_mag = 3'd4;
      5'b100_10: ac_mag = 3'd5;
      5'b100_11: ac_mag = 3'd2;
      5'b110_10: ac_mag = 3'd6;
      5'b110_11: ac_mag = 3'd3;
      5'b111_10: ac_mag = 3'd7;
      5'b111_11: ac_mag = 3'd2;
      default:   ac_mag = 3'd1;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ibvd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibvd_ctrl
// Sequencer: walks the bits of a byte and orders datapath actions.
// ----------------------------------------------------------------------------
`default_nettype none

module ibvd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  ibvd_pkg::sts_t     sts,
  output ibvd_pkg::cmd_t     cmd
);
  import ibvd_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bit_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    bit_nxt     = bit_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.kind    = KIND_DC;
    cmd.bit_idx = bit_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          bit_nxt   = 3'd0;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts.halted) begin
          state_nxt = ST_FINAL;
        end else begin
          cmd.shift = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        case (sts.act)
          ACT_FAIL: begin
            if (sts.push_ok) begin
              cmd.push  = 1'b1;
              cmd.kind  = KIND_ERR;
              cmd.fail  = 1'b1;
              state_nxt = ST_FINAL;
            end
          end
          ACT_DC: begin
            if (sts.push_ok) begin
              cmd.push  = 1'b1;
              cmd.kind  = KIND_DC;
              cmd.dc    = 1'b1;
              bit_nxt   = bit_r + 3'd1;
              state_nxt = (bit_r == 3'd7) ? ST_FINAL : ST_SHIFT;
            end
          end
          ACT_EOB: begin
            cmd.eob   = 1'b1;
            state_nxt = ST_BEND;
          end
          ACT_COEF: begin
            cmd.coef  = 1'b1;
            state_nxt = sts.k_over ? ST_BEND : ST_MUL1;
          end
          default: begin
            bit_nxt   = bit_r + 3'd1;
            state_nxt = (bit_r == 3'd7) ? ST_FINAL : ST_SHIFT;
          end
        endcase
      end
      ST_MUL1: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        if (sts.push_ok) begin
          cmd.push    = 1'b1;
          cmd.kind    = KIND_AC;
          cmd.ac_done = 1'b1;
          if (sts.k_last) begin
            state_nxt = ST_BEND;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            state_nxt = (bit_r == 3'd7) ? ST_FINAL : ST_SHIFT;
          end
        end
      end
      ST_BEND: begin
        if (sts.push_ok) begin
          cmd.push  = 1'b1;
          cmd.kind  = KIND_BLK;
          cmd.bend  = 1'b1;
          state_nxt = ST_BLIM;
        end
      end
      ST_BLIM: begin
        if (sts.lim_hit) begin
          if (sts.push_ok) begin
            cmd.push  = 1'b1;
            cmd.kind  = KIND_END;
            cmd.halt  = 1'b1;
            state_nxt = ST_FINAL;
          end
        end else begin
          bit_nxt   = bit_r + 3'd1;
          state_nxt = (bit_r == 3'd7) ? ST_FINAL : ST_SHIFT;
        end
      end
      ST_FINAL: begin
        if (sts.final_flag && !sts.halted) begin
          if (sts.push_ok) begin
            cmd.push  = 1'b1;
            cmd.kind  = KIND_END;
            cmd.halt  = 1'b1;
            state_nxt = ST_FLUSH;
          end
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_v) begin
          state_nxt = ST_IDLE;
        end else if (sts.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ibvd_dp.sv =====
// ----------------------------------------------------------------------------
// ibvd_dp
// Datapath: code shifter, DC/AC prefix decode, predictor, dequantizer,
// configuration registers and the two-deep result holding stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ibvd_dp #(
  parameter int MAX_BLOCKS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         in_stream_byte,
  input  wire logic               in_frame_start,
  input  wire logic               in_final_byte,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  ibvd_pkg::cmd_t          cmd,
  output ibvd_pkg::sts_t          sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_kind,
  output logic [3:0]              out_position,
  output logic signed [24:0]      out_coef_value,
  output logic [5:0]              out_run_length,
  output logic signed [8:0]       out_raw_level,
  output logic [11:0]             out_block_number,
  output logic                    out_last
);
  import ibvd_pkg::*;

  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (CW > 13) ? CW : 13;

  // configuration
  logic [7:0]         qscale_r;
  logic [63:0]        qlow_r, qhigh_r;
  logic [12:0]        blimit_r;
  logic signed [15:0] dcstart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qscale_r  <= 8'd1;
      qlow_r    <= '0;
      qhigh_r   <= '0;
      blimit_r  <= 13'd1152;
      dcstart_r <= 16'sd512;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QSCALE: qscale_r  <= cfg_data[7:0];
        CFG_QLOW:   qlow_r    <= cfg_data;
        CFG_QHIGH:  qhigh_r   <= cfg_data;
        CFG_BLIMIT: blimit_r  <= cfg_data[12:0];
        CFG_DCSTRT: dcstart_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // decoder state
  logic [7:0]         byte_r;
  logic               final_r;
  logic [27:0]        lcode_r, rcode_r;   // left- and right-aligned copies
  logic [4:0]         len_r;
  logic               phase_r;            // 0: DC size, 1: AC
  logic signed [15:0] pred_r;
  logic [4:0]         cidx_r;
  logic               first_r;
  logic [CW-1:0]      blk_r;
  logic               halt_r;
  logic [5:0]         run_r;
  logic signed [8:0]  lvl_r;
  logic [3:0]         k_r;
  logic signed [17:0] p1_r;

  logic               bit_in;
  logic [27:0]        lcode_nxt;
  assign bit_in    = byte_r[3'd7 - cmd.bit_idx];
  assign lcode_nxt = lcode_r | (bit_in ? (28'h8000000 >> len_r) : 28'h0);

  // DC size decode
  act_t               dc_act;
  logic [3:0]         lo1;
  logic               lo1_done;
  logic [4:0]         plen;
  logic [3:0]         dsize;
  logic [8:0]         dmask, dv;
  logic signed [9:0]  diff;
  logic signed [16:0] psum;
  logic signed [15:0] pred_new;

  always_comb begin
    lo1      = 4'd0;
    lo1_done = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (!lo1_done) begin
        if (lcode_r[27 - i]) lo1 = lo1 + 4'd1;
        else lo1_done = 1'b1;
      end
    end
    dc_act = ACT_NONE;
    plen   = 5'd2;
    dsize  = 4'd0;
    if (len_r >= 5'd2) begin
      if (!lcode_r[27]) begin
        plen   = 5'd2;
        dsize  = lcode_r[26] ? 4'd2 : 4'd1;
        dc_act = ACT_DC;
      end else if (!lcode_r[26]) begin
        if (len_r >= 5'd3) begin
          plen   = 5'd3;
          dsize  = lcode_r[25] ? 4'd3 : 4'd0;
          dc_act = ACT_DC;
        end
      end else if (lo1 >= 4'd7) begin
        dc_act = ACT_FAIL;
      end else if ({1'b0, lo1} != len_r) begin
        plen   = {1'b0, lo1} + 5'd1;
        dsize  = lo1 + 4'd2;
        dc_act = ACT_DC;
      end
    end
    if (dc_act == ACT_DC && len_r < plen + {1'b0, dsize}) dc_act = ACT_NONE;
    dmask = 9'((9'd1 << dsize) - 9'd1);
    dv    = {1'b0, rcode_r[7:0]} & dmask;
    if (dsize != 4'd0 && !dv[dsize - 4'd1])
      diff = $signed({1'b0, dv}) - $signed({1'b0, dmask});
    else
      diff = $signed({1'b0, dv});
    psum = {pred_r[15], pred_r} + 17'(diff);
    if (psum > 17'sd32767)       pred_new = 16'sd32767;
    else if (psum < -17'sd32768) pred_new = -16'sd32768;
    else                         pred_new = psum[15:0];
  end

  // AC run/level decode
  act_t              ac_act;
  logic [3:0]        lz;
  logic              lz_done;
  logic [4:0]        z;
  logic              b1, b2, b3;
  logic [5:0]        ac_rn;
  logic signed [8:0] ac_lv;
  logic [7:0]        esc_lv;
  logic [2:0]        mag;

  always_comb begin
    lz      = 4'd0;
    lz_done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!lz_done) begin
        if (!lcode_r[27 - i]) lz = lz + 4'd1;
        else lz_done = 1'b1;
      end
    end
    z      = ({1'b0, lz} > len_r) ? len_r : {1'b0, lz};
    b1     = lcode_r[5'd26 - z];
    b2     = lcode_r[5'd25 - z];
    b3     = lcode_r[5'd24 - z];
    esc_lv = lcode_r[15:8];
    mag    = ac_mag(z[2:0], {b1, b2});
    ac_act = ACT_NONE;
    ac_rn  = 6'd0;
    ac_lv  = 9'sd0;
    if (z >= 5'd8) begin
      ac_act = ACT_FAIL;
    end else if (z != len_r) begin
      case (z)
        5'd0: begin
          if (first_r) begin
            if (len_r >= 5'd2) begin
              ac_act = ACT_COEF;
              ac_lv  = lcode_r[26] ? -9'sd1 : 9'sd1;
            end
          end else if (len_r >= 5'd2) begin
            if (!lcode_r[26]) begin
              ac_act = ACT_EOB;
            end else if (len_r >= 5'd3) begin
              ac_act = ACT_COEF;
              ac_lv  = lcode_r[25] ? -9'sd1 : 9'sd1;
            end
          end
        end
        5'd1: begin
          if (len_r >= 5'd3) begin
            if (lcode_r[25]) begin
              if (len_r >= 5'd4) begin
                ac_act = ACT_COEF;
                ac_rn  = 6'd1;
                ac_lv  = lcode_r[24] ? -9'sd1 : 9'sd1;
              end
            end else if (len_r >= 5'd5) begin
              ac_act = ACT_COEF;
              if (!lcode_r[24]) begin
                ac_lv = lcode_r[23] ? -9'sd2 : 9'sd2;
              end else begin
                ac_rn = 6'd2;
                ac_lv = lcode_r[23] ? -9'sd1 : 9'sd1;
              end
            end
          end
        end
        5'd5: begin
          // escape: 6-bit run, 8-bit level, optional 8-bit extension
          if (len_r >= 5'd20) begin
            ac_rn = lcode_r[21:16];
            if (esc_lv == 8'd0 || esc_lv == 8'd128) begin
              if (len_r >= 5'd28) begin
                ac_act = ACT_COEF;
                ac_lv  = (esc_lv == 8'd128) ? $signed({1'b1, lcode_r[7:0]})
                                            : $signed({1'b0, lcode_r[7:0]});
              end
            end else begin
              ac_act = ACT_COEF;
              ac_lv  = $signed({esc_lv[7], esc_lv});
            end
          end
        end
        default: begin
          if (len_r >= z + 5'd4) begin
            ac_act = ACT_COEF;
            ac_rn  = ac_run(z[2:0], {b1, b2});
            ac_lv  = b3 ? -$signed({6'd0, mag}) : $signed({6'd0, mag});
          end
        end
      endcase
    end
  end

  act_t               act;
  logic [6:0]         ksum;
  logic [7:0]         qsel;
  logic [127:0]       qtab;
  logic signed [26:0] acv;
  logic [CMPW-1:0]    blk_ext;

  assign act     = phase_r ? ac_act : dc_act;
  assign ksum    = {2'b00, cidx_r} + {1'b0, ac_rn};
  assign qtab    = {qhigh_r, qlow_r};
  assign qsel    = qtab[{k_r, 3'b000} +: 8];
  assign acv     = p1_r * $signed({1'b0, qscale_r});
  assign blk_ext = CMPW'(blk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcode_r <= '0;
      rcode_r <= '0;
      len_r   <= '0;
      phase_r <= 1'b0;
      pred_r  <= 16'sd512;
      cidx_r  <= 5'd1;
      first_r <= 1'b1;
      blk_r   <= '0;
      halt_r  <= 1'b0;
      final_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        final_r <= in_final_byte;
        if (in_frame_start) begin
          lcode_r <= '0;
          rcode_r <= '0;
          len_r   <= '0;
          phase_r <= 1'b0;
          pred_r  <= dcstart_r;
          cidx_r  <= 5'd1;
          first_r <= 1'b1;
          blk_r   <= '0;
          halt_r  <= 1'b0;
        end
      end
      if (cmd.shift) begin
        lcode_r <= lcode_nxt;
        rcode_r <= {rcode_r[26:0], bit_in};
        len_r   <= len_r + 5'd1;
      end
      if (cmd.dc) begin
        pred_r  <= pred_new;
        phase_r <= 1'b1;
        cidx_r  <= 5'd1;
        first_r <= 1'b1;
      end
      if (cmd.eob || cmd.coef) first_r <= 1'b0;
      if (cmd.ac_done) cidx_r <= {1'b0, k_r} + 5'd1;
      if (cmd.bend) begin
        blk_r   <= blk_r + 1'b1;
        phase_r <= 1'b0;
      end
      if (cmd.fail || cmd.halt) halt_r <= 1'b1;
      if (cmd.fail || cmd.halt || cmd.dc || cmd.coef || cmd.bend) begin
        lcode_r <= '0;
        rcode_r <= '0;
        len_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) byte_r <= in_stream_byte;
    if (cmd.coef) begin
      run_r <= ac_rn;
      lvl_r <= ac_lv;
      k_r   <= ksum[3:0];
    end
    if (cmd.mul) p1_r <= lvl_r * $signed({1'b0, qsel});
  end

  // result holding: pend_r waits until the next result or the byte's end
  // decides its last flag
  logic               pend_v_r, out_v_r;
  kind_t              pend_kind_r;
  logic [3:0]         pend_pos_r;
  logic signed [24:0] pend_val_r;
  logic [5:0]         pend_run_r;
  logic signed [8:0]  pend_lvl_r;
  logic [11:0]        pend_bn_r;
  kind_t              kind_r;
  logic [3:0]         pos_r;
  logic signed [24:0] val_r;
  logic [5:0]         orun_r;
  logic signed [8:0]  olvl_r;
  logic [11:0]        bn_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else if (cmd.push) begin
      pend_v_r <= 1'b1;
      if (pend_v_r)       out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end else if (cmd.flush) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_kind_r <= cmd.kind;
      pend_pos_r  <= 4'd0;
      pend_val_r  <= 25'sd0;
      pend_run_r  <= 6'd0;
      pend_lvl_r  <= 9'sd0;
      pend_bn_r   <= blk_ext[11:0];
      case (cmd.kind)
        KIND_DC: begin
          pend_val_r <= {{8{pred_new[15]}}, pred_new, 1'b0};
          pend_lvl_r <= diff[8:0];
        end
        KIND_AC: begin
          pend_pos_r <= zz_pos(k_r);
          pend_val_r <= acv[24:0];
          pend_run_r <= run_r;
          pend_lvl_r <= lvl_r;
        end
        default: ;
      endcase
    end
    if ((cmd.push && pend_v_r) || cmd.flush) begin
      kind_r <= pend_kind_r;
      pos_r  <= pend_pos_r;
      val_r  <= pend_val_r;
      orun_r <= pend_run_r;
      olvl_r <= pend_lvl_r;
      bn_r   <= pend_bn_r;
      last_r <= cmd.flush;
    end
  end

  always_comb begin
    sts            = '0;
    sts.act        = act;
    sts.k_over     = ksum >= 7'(COEFS_PER_BLOCK);
    sts.k_last     = ({1'b0, k_r} + 5'd1) >= 5'(COEFS_PER_BLOCK);
    sts.lim_hit    = (blk_ext >= CMPW'(blimit_r)) || (blk_ext >= CMPW'(MAX_BLOCKS));
    sts.halted     = halt_r;
    sts.final_flag = final_r;
    sts.push_ok    = !pend_v_r || !out_v_r || out_ready;
    sts.flush_ok   = !out_v_r || out_ready;
    sts.pend_v     = pend_v_r;
  end

  assign out_valid        = out_v_r;
  assign out_kind         = kind_r;
  assign out_position     = pos_r;
  assign out_coef_value   = val_r;
  assign out_run_length   = orun_r;
  assign out_raw_level    = olvl_r;
  assign out_block_number = bn_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/intra_block_vlc_decoder_top.sv =====
// ----------------------------------------------------------------------------
// intra_block_vlc_decoder_top
// Bit-serial decoder of DC and run/level AC codes of intra 4x4 blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one bitstream byte per
//   transfer, MSB decoded first, with frame_start and final_byte flags.
//   Output channel (out_valid/out_ready) carries the results decoded from a
//   byte, if any; out_last marks the final result of a byte.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Sequence:
//   A byte is loaded, then each code bit is shifted in and decoded; an AC
//   coefficient adds two registered multiplies, a block end adds a block-end
//   and a block-limit step, and a final and a flush step close the byte.
//   The next byte is taken once the current byte's last result sits in the
//   output register.
// Reset: rst_n (synchronous) clears the decoder to the start of a frame
//   with default configuration; no result is pending.
// Stall: a held result waits in a one-deep holding stage behind the output
//   register; decoding pauses only when both are full and out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module intra_block_vlc_decoder_top #(
  parameter int MAX_BLOCKS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_stream_byte,
  input  wire logic               in_frame_start,
  input  wire logic               in_final_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_kind,
  output logic [3:0]              out_position,
  output logic signed [24:0]      out_coef_value,
  output logic [5:0]              out_run_length,
  output logic signed [8:0]       out_raw_level,
  output logic [11:0]             out_block_number,
  output logic                    out_last,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import ibvd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ibvd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ibvd_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_stream_byte   (in_stream_byte),
    .in_frame_start   (in_frame_start),
    .in_final_byte    (in_final_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_position     (out_position),
    .out_coef_value   (out_coef_value),
    .out_run_length   (out_run_length),
    .out_raw_level    (out_raw_level),
    .out_block_number (out_block_number),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ibvd_check.sv =====
// ----------------------------------------------------------------------------
// ibvd_check
// Port-level checks of the decoder's result channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ibvd_check (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         out_kind,
  input wire logic [3:0]         out_position,
  input wire logic signed [24:0] out_coef_value,
  input wire logic [5:0]         out_run_length,
  input wire logic signed [8:0]  out_raw_level
);
  import ibvd_pkg::*;

  logic stalled;
  logic marker;
  assign stalled = out_valid && !out_ready;
  assign marker  = out_valid && (out_kind == KIND_BLK || out_kind == KIND_ERR ||
                                 out_kind == KIND_END);

  `IBVD_ASSERT_NEXT(a_hold, stalled, out_valid && $stable(out_kind) && $stable(out_coef_value))
  `IBVD_ASSERT_NOW(a_kind, out_valid, out_kind <= KIND_END)
  `IBVD_ASSERT_NOW(a_marker_zero, marker, out_coef_value == 0 && out_raw_level == 0)
  `IBVD_ASSERT_NOW(a_non_ac, out_valid && out_kind != KIND_AC, out_position == 0 && out_run_length == 0)

endmodule

bind intra_block_vlc_decoder_top ibvd_check u_ibvd_check (.*);

`default_nettype wire
